### src/dmix_pkg.sv
// ----------------------------------------------------------------------------
// dmix_pkg
// Shared types and constants for the differential drive mixer: register
// indexes, fixed-point constants, and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package dmix_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ACCEL_RATE  = 3'd0;
    localparam logic [2:0] REG_DECEL_RATE  = 3'd1;
    localparam logic [2:0] REG_EXPO_AMOUNT = 3'd2;
    localparam logic [2:0] REG_STILL_SHARE = 3'd3;
    localparam logic [2:0] REG_MAX_TURN    = 3'd4;
    localparam logic [2:0] REG_MAX_WHEEL   = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [15:0] ACCEL_RATE_RST  = 16'd1024;
    localparam logic [15:0] DECEL_RATE_RST  = 16'd384;
    localparam logic [15:0] EXPO_AMOUNT_RST = 16'd11469;
    localparam logic [15:0] STILL_SHARE_RST = 16'd32768;
    localparam logic [14:0] MAX_TURN_RST    = 15'd1512;
    localparam logic [14:0] MAX_WHEEL_RST   = 15'd3000;

    // unity in Q0.15
    localparam logic [16:0] ONE_Q15 = 17'd32768;

    // battery sample window: 20 * |raw| below unity
    localparam int          SAMPLE_DIV   = 20;
    localparam logic [14:0] ALLOW_LIMIT  = 15'((32768 + SAMPLE_DIV - 1) / SAMPLE_DIV);

    // lightbar thresholds in percent
    localparam logic [6:0] LOW_PCT = 7'd20;
    localparam logic [6:0] MID_PCT = 7'd40;

    // lightbar colour codes
    localparam logic [1:0] COLOUR_RED   = 2'd0;
    localparam logic [1:0] COLOUR_AMBER = 2'd1;
    localparam logic [1:0] COLOUR_GREEN = 2'd2;

    // drive modes
    localparam logic MODE_STOP   = 1'b0;
    localparam logic MODE_MANUAL = 1'b1;

    // operand selection for the shared multiplier
    typedef enum logic [3:0] {
        MUL_RATE = 4'd0,  // rate * tick length
        MUL_SQ   = 4'd1,  // |stick| squared
        MUL_CUBE = 4'd2,  // square * |stick|
        MUL_ELIN = 4'd3,  // (1 - expo) * |stick|
        MUL_ECUB = 4'd4,  // expo * cube
        MUL_GATE = 4'd5,  // (1 - share) * |ramp|
        MUL_BASE = 4'd6,  // |ramp| * wheel ceiling
        MUL_TA   = 4'd7,  // expo curve * turn ceiling
        MUL_TB   = 4'd8   // previous product * gate
    } mul_sel_t;

    // where the previous product lands
    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_RAMP = 3'd1,
        CAP_CUBE = 3'd2,
        CAP_ELIN = 3'd3,
        CAP_EXPO = 3'd4,
        CAP_GATE = 3'd5,
        CAP_BASE = 3'd6,
        CAP_TURN = 3'd7
    } cap_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        cap_sel_t cap;
        logic     publish;
    } dmix_cmd_t;

endpackage

### src/dmix_ctrl.sv
// ----------------------------------------------------------------------------
// dmix_ctrl
// Sequencer for one control tick: accepts a beat, steps the shared
// multiplier through its products, then loads the output register.
// ----------------------------------------------------------------------------
module dmix_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output dmix_pkg::dmix_cmd_t cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_M_RATE = 12'b0000_0000_0010,
        S_M_SQ   = 12'b0000_0000_0100,
        S_M_CUBE = 12'b0000_0000_1000,
        S_M_ELIN = 12'b0000_0001_0000,
        S_M_ECUB = 12'b0000_0010_0000,
        S_M_GATE = 12'b0000_0100_0000,
        S_M_BASE = 12'b0000_1000_0000,
        S_M_TA   = 12'b0001_0000_0000,
        S_M_TB   = 12'b0010_0000_0000,
        S_MIX    = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.mul_sel = dmix_pkg::MUL_RATE;
        cmd.cap     = dmix_pkg::CAP_NONE;
        cmd.publish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = S_M_RATE;
                end
            end
            S_M_RATE:
            begin
                cmd.mul_sel = dmix_pkg::MUL_RATE;
                state_next  = S_M_SQ;
            end
            S_M_SQ:
            begin
                cmd.mul_sel = dmix_pkg::MUL_SQ;
                cmd.cap     = dmix_pkg::CAP_RAMP;
                state_next  = S_M_CUBE;
            end
            S_M_CUBE:
            begin
                cmd.mul_sel = dmix_pkg::MUL_CUBE;
                state_next  = S_M_ELIN;
            end
            S_M_ELIN:
            begin
                cmd.mul_sel = dmix_pkg::MUL_ELIN;
                cmd.cap     = dmix_pkg::CAP_CUBE;
                state_next  = S_M_ECUB;
            end
            S_M_ECUB:
            begin
                cmd.mul_sel = dmix_pkg::MUL_ECUB;
                cmd.cap     = dmix_pkg::CAP_ELIN;
                state_next  = S_M_GATE;
            end
            S_M_GATE:
            begin
                cmd.mul_sel = dmix_pkg::MUL_GATE;
                cmd.cap     = dmix_pkg::CAP_EXPO;
                state_next  = S_M_BASE;
            end
            S_M_BASE:
            begin
                cmd.mul_sel = dmix_pkg::MUL_BASE;
                cmd.cap     = dmix_pkg::CAP_GATE;
                state_next  = S_M_TA;
            end
            S_M_TA:
            begin
                cmd.mul_sel = dmix_pkg::MUL_TA;
                cmd.cap     = dmix_pkg::CAP_BASE;
                state_next  = S_M_TB;
            end
            S_M_TB:
            begin
                cmd.mul_sel = dmix_pkg::MUL_TB;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.cap    = dmix_pkg::CAP_TURN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold here until the output register can take the beat
                if (slot_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on publish, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/dmix_datapath.sv
// ----------------------------------------------------------------------------
// dmix_datapath
// Configuration registers, throttle ramp state, one shared 32x16 multiplier
// with its product register, and the output register of the mixer.
// ----------------------------------------------------------------------------
module dmix_datapath (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    // input beat
    input  logic                link_up,
    input  logic [14:0]         right_trigger,
    input  logic [14:0]         left_trigger,
    input  logic signed [15:0]  stick_x,
    input  logic [15:0]         tick_length,
    input  logic                battery_lockout,
    input  logic                battery_fresh,
    input  logic [6:0]          battery_percent,
    // command
    input  dmix_pkg::dmix_cmd_t cmd,
    // result beat
    output logic                drive_mode,
    output logic signed [15:0]  left_target,
    output logic signed [15:0]  right_target,
    output logic signed [15:0]  throttle_level,
    output logic                sample_allow,
    output logic                light_update,
    output logic [1:0]          light_colour
);

    // configuration registers
    logic [15:0] accel_reg;
    logic [15:0] decel_reg;
    logic [15:0] expo_reg;
    logic [15:0] share_reg;
    logic [14:0] mtt_reg;
    logic [14:0] mwt_reg;

    // latched input beat
    logic               link_reg;
    logic               lock_reg;
    logic               fresh_reg;
    logic [6:0]         pct_reg;
    logic signed [15:0] raw_reg;
    logic signed [15:0] sx_reg;
    logic [15:0]        dt_reg;

    // work registers
    logic signed [15:0] ramp_reg;
    logic signed [15:0] ramp_next;
    logic [47:0]        prod_reg;
    logic [15:0]        cube_reg;
    logic [30:0]        elin_reg;
    logic [15:0]        expo_e_reg;
    logic [15:0]        gate_reg;
    logic [14:0]        base_reg;
    logic [14:0]        turn_reg;

    // output register
    logic               mode_out_reg;
    logic [15:0]        left_out_reg;
    logic [15:0]        right_out_reg;
    logic [15:0]        thr_out_reg;
    logic               allow_out_reg;
    logic               lupd_out_reg;
    logic [1:0]         colour_out_reg;

    // combinational helpers
    logic [15:0]        raw_neg;
    logic [14:0]        araw;
    logic [15:0]        ramp_neg;
    logic [14:0]        aramp;
    logic [15:0]        asx;
    logic [15:0]        expo_sat;
    logic [15:0]        share_sat;
    logic [15:0]        expo_inv;
    logic [15:0]        share_inv;
    logic [15:0]        rate_sel;
    logic [31:0]        op_a;
    logic [15:0]        op_b;
    logic [47:0]        prod_next;
    logic signed [23:0] diff;
    logic signed [23:0] step_pos;
    logic signed [23:0] step_neg;
    logic signed [23:0] diff_lim;
    logic [31:0]        expo_sum;
    logic [16:0]        gate_sum;
    logic [14:0]        head;
    logic [14:0]        base_lim;
    logic [16:0]        sbase;
    logic [16:0]        sturn;
    logic [16:0]        left_sum;
    logic [16:0]        right_sum;
    logic               mode_now;
    logic [1:0]         colour_now;

    // magnitudes and saturated blends
    always_comb
    begin
        raw_neg   = 16'(-raw_reg);
        araw      = raw_reg[15] ? raw_neg[14:0] : raw_reg[14:0];
        ramp_neg  = 16'(-ramp_reg);
        aramp     = ramp_reg[15] ? ramp_neg[14:0] : ramp_reg[14:0];
        asx       = sx_reg[15] ? 16'(-sx_reg) : 16'(sx_reg);
        expo_sat  = (17'(expo_reg) > dmix_pkg::ONE_Q15) ? 16'(dmix_pkg::ONE_Q15) : expo_reg;
        share_sat = (17'(share_reg) > dmix_pkg::ONE_Q15) ? 16'(dmix_pkg::ONE_Q15) : share_reg;
        expo_inv  = 16'(dmix_pkg::ONE_Q15 - 17'(expo_sat));
        share_inv = 16'(dmix_pkg::ONE_Q15 - 17'(share_sat));
        // deceleration rate when |raw| is below |ramp|, else acceleration rate
        rate_sel  = (araw < aramp) ? decel_reg : accel_reg;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            dmix_pkg::MUL_RATE:
            begin
                op_a = 32'(rate_sel);
                op_b = dt_reg;
            end
            dmix_pkg::MUL_SQ:
            begin
                op_a = 32'(asx);
                op_b = asx;
            end
            dmix_pkg::MUL_CUBE:
            begin
                op_a = prod_reg[31:0];
                op_b = asx;
            end
            dmix_pkg::MUL_ELIN:
            begin
                op_a = 32'(expo_inv);
                op_b = asx;
            end
            dmix_pkg::MUL_ECUB:
            begin
                op_a = 32'(expo_sat);
                op_b = cube_reg;
            end
            dmix_pkg::MUL_GATE:
            begin
                op_a = 32'(share_inv);
                op_b = 16'(aramp);
            end
            dmix_pkg::MUL_BASE:
            begin
                op_a = 32'(aramp);
                op_b = 16'(mwt_reg);
            end
            dmix_pkg::MUL_TA:
            begin
                op_a = 32'(expo_e_reg);
                op_b = 16'(mtt_reg);
            end
            dmix_pkg::MUL_TB:
            begin
                op_a = prod_reg[31:0];
                op_b = gate_reg;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 16'd0;
            end
        endcase
        prod_next = 48'(op_a) * 48'(op_b);
    end

    // ramp step: move toward raw by at most the rate-limited step; zero on link loss or lockout
    always_comb
    begin
        diff     = 24'(raw_reg) - 24'(ramp_reg);
        step_pos = signed'({1'b0, prod_reg[31:9]});
        step_neg = -step_pos;
        if (diff > step_pos)
        begin
            diff_lim = step_pos;
        end
        else if (diff < step_neg)
        begin
            diff_lim = step_neg;
        end
        else
        begin
            diff_lim = diff;
        end
        if (!link_reg || lock_reg)
        begin
            ramp_next = 16'sd0;
        end
        else
        begin
            ramp_next = 16'(24'(ramp_reg) + diff_lim);
        end
    end

    // expo curve and steering gate sums
    assign expo_sum = 32'(elin_reg) + prod_reg[31:0];
    assign gate_sum = 17'(share_sat) + 17'(prod_reg[30:15]);

    // final mix: steering first, forward speed within what is left
    always_comb
    begin
        head      = (mwt_reg > turn_reg) ? 15'(mwt_reg - turn_reg) : 15'd0;
        base_lim  = (base_reg > head) ? head : base_reg;
        sbase     = ramp_reg[15] ? 17'(-{2'b00, base_lim}) : {2'b00, base_lim};
        sturn     = sx_reg[15] ? 17'(-{2'b00, turn_reg}) : {2'b00, turn_reg};
        left_sum  = 17'(sbase + sturn);
        right_sum = 17'(sbase - sturn);
        mode_now  = link_reg && !lock_reg;
    end

    // lightbar colour from a fresh reading
    always_comb
    begin
        if (!(link_reg && fresh_reg))
        begin
            colour_now = dmix_pkg::COLOUR_RED;
        end
        else if (lock_reg || (pct_reg < dmix_pkg::LOW_PCT))
        begin
            colour_now = dmix_pkg::COLOUR_RED;
        end
        else if (pct_reg < dmix_pkg::MID_PCT)
        begin
            colour_now = dmix_pkg::COLOUR_AMBER;
        end
        else
        begin
            colour_now = dmix_pkg::COLOUR_GREEN;
        end
    end

    // configuration registers and ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= dmix_pkg::ACCEL_RATE_RST;
            decel_reg <= dmix_pkg::DECEL_RATE_RST;
            expo_reg  <= dmix_pkg::EXPO_AMOUNT_RST;
            share_reg <= dmix_pkg::STILL_SHARE_RST;
            mtt_reg   <= dmix_pkg::MAX_TURN_RST;
            mwt_reg   <= dmix_pkg::MAX_WHEEL_RST;
            ramp_reg  <= 16'sd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dmix_pkg::REG_ACCEL_RATE:  accel_reg <= cfg_data;
                    dmix_pkg::REG_DECEL_RATE:  decel_reg <= cfg_data;
                    dmix_pkg::REG_EXPO_AMOUNT: expo_reg  <= cfg_data;
                    dmix_pkg::REG_STILL_SHARE: share_reg <= cfg_data;
                    dmix_pkg::REG_MAX_TURN:    mtt_reg   <= cfg_data[14:0];
                    dmix_pkg::REG_MAX_WHEEL:   mwt_reg   <= cfg_data[14:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.cap == dmix_pkg::CAP_RAMP)
            begin
                ramp_reg <= ramp_next;
            end
        end
    end

    // input latch and multiplier pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            link_reg  <= link_up;
            lock_reg  <= battery_lockout;
            fresh_reg <= battery_fresh;
            pct_reg   <= battery_percent;
            raw_reg   <= signed'(16'({1'b0, right_trigger}) - 16'({1'b0, left_trigger}));
            sx_reg    <= stick_x;
            dt_reg    <= tick_length;
        end
        prod_reg <= prod_next;
        case (cmd.cap)
            dmix_pkg::CAP_CUBE: cube_reg   <= prod_reg[45:30];
            dmix_pkg::CAP_ELIN: elin_reg   <= prod_reg[30:0];
            dmix_pkg::CAP_EXPO: expo_e_reg <= expo_sum[30:15];
            dmix_pkg::CAP_GATE: gate_reg   <= gate_sum[15:0];
            dmix_pkg::CAP_BASE: base_reg   <= prod_reg[29:15];
            dmix_pkg::CAP_TURN: turn_reg   <= prod_reg[44:30];
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            mode_out_reg   <= mode_now ? dmix_pkg::MODE_MANUAL : dmix_pkg::MODE_STOP;
            left_out_reg   <= mode_now ? left_sum[15:0] : 16'd0;
            right_out_reg  <= mode_now ? right_sum[15:0] : 16'd0;
            thr_out_reg    <= ramp_reg;
            allow_out_reg  <= link_reg && (araw < dmix_pkg::ALLOW_LIMIT);
            lupd_out_reg   <= link_reg && fresh_reg;
            colour_out_reg <= colour_now;
        end
    end

    assign drive_mode     = mode_out_reg;
    assign left_target    = signed'(left_out_reg);
    assign right_target   = signed'(right_out_reg);
    assign throttle_level = signed'(thr_out_reg);
    assign sample_allow   = allow_out_reg;
    assign light_update   = lupd_out_reg;
    assign light_colour   = colour_out_reg;

endmodule

### src/differential_drive_mixer.sv
// An accepted input beat passes the nine multiply states, S_MIX and S_DONE to out_valid.
// A new beat is taken only in S_IDLE, since the single shared 32x16
// multiplier issues nine products per tick; output backpressure adds wait.
// The next beat is taken while a finished result still waits at the output.
// Reset: configuration returns to defaults, throttle ramp clears, no result.
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Arcade mixer for a differential drive: slew-limited throttle, cubic expo
// steering with a speed gate, wheel targets, stop handling and lightbar.
// ----------------------------------------------------------------------------
module differential_drive_mixer (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                cfg_we,
    input  logic [dmix_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dmix_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                link_up,
    input  logic [14:0]                         right_trigger,
    input  logic [14:0]                         left_trigger,
    input  logic signed [15:0]                  stick_x,
    input  logic [15:0]                         tick_length,
    input  logic                                battery_lockout,
    input  logic                                battery_fresh,
    input  logic [6:0]                          battery_percent,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                drive_mode,
    output logic signed [15:0]                  left_target,
    output logic signed [15:0]                  right_target,
    output logic signed [15:0]                  throttle_level,
    output logic                                sample_allow,
    output logic                                light_update,
    output logic [1:0]                          light_colour
);

    dmix_pkg::dmix_cmd_t cmd;

    // sequencer
    dmix_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic and storage
    dmix_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .link_up         (link_up),
        .right_trigger   (right_trigger),
        .left_trigger    (left_trigger),
        .stick_x         (stick_x),
        .tick_length     (tick_length),
        .battery_lockout (battery_lockout),
        .battery_fresh   (battery_fresh),
        .battery_percent (battery_percent),
        .cmd             (cmd),
        .drive_mode      (drive_mode),
        .left_target     (left_target),
        .right_target    (right_target),
        .throttle_level  (throttle_level),
        .sample_allow    (sample_allow),
        .light_update    (light_update),
        .light_colour    (light_colour)
    );

endmodule
